>>> rtl/isr_pkg.sv
// isr_pkg: types, section codes and size constants for the image section router
// used by isr_parser and ines_image_section_router; no dependencies
package isr_pkg;

  localparam int unsigned HEADER_BYTES   = 16;
  localparam int unsigned TRAINER_BYTES  = 512;
  localparam int unsigned PRG_UNIT_BYTES = 16384;
  localparam int unsigned CHR_UNIT_BYTES = 8192;
  localparam int unsigned INST_ROM_BYTES = 8192;

  localparam int unsigned SEC_W = 3;
  localparam int unsigned OFF_W = 22;
  localparam int unsigned LEN_W = OFF_W + 1;

  localparam logic [SEC_W-1:0] SEC_HEADER   = 3'd0;
  localparam logic [SEC_W-1:0] SEC_TRAINER  = 3'd1;
  localparam logic [SEC_W-1:0] SEC_PRG      = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CHR      = 3'd3;
  localparam logic [SEC_W-1:0] SEC_INST     = 3'd4;
  localparam logic [SEC_W-1:0] SEC_TRAILING = 3'd5;

  localparam logic [OFF_W-1:0] OFFSET_MAX = {OFF_W{1'b1}};

  localparam logic [OFF_W-1:0] HDR_PRG_OFF  = OFF_W'(4);
  localparam logic [OFF_W-1:0] HDR_CHR_OFF  = OFF_W'(5);
  localparam logic [OFF_W-1:0] HDR_FLG6_OFF = OFF_W'(6);
  localparam logic [OFF_W-1:0] HDR_FLG7_OFF = OFF_W'(7);
  localparam int unsigned      TRAINER_BIT  = 2;
  localparam int unsigned      INST_BIT     = 1;

  typedef struct packed {
    logic [7:0] rom_byte;
    logic       image_start;
  } isr_in_t;

  typedef struct packed {
    logic [SEC_W-1:0] section;
    logic [OFF_W-1:0] section_offset;
    logic [7:0]       byte_out;
    logic [7:0]       prg_banks;
    logic [7:0]       chr_banks;
    logic             trainer_present;
    logic             inst_rom_present;
  } isr_out_t;

  typedef struct packed {
    logic [7:0] prg_banks;
    logic [7:0] chr_banks;
    logic       trainer;
    logic       inst;
  } isr_hdr_t;

  function automatic logic [LEN_W-1:0] section_len(input logic [SEC_W-1:0] sec,
                                                   input isr_hdr_t hdr);
    logic [LEN_W-1:0] len;
    len = '0;
    case (sec)
      SEC_HEADER:  len = LEN_W'(HEADER_BYTES);
      SEC_TRAINER: len = hdr.trainer ? LEN_W'(TRAINER_BYTES) : '0;
      SEC_PRG:     len = LEN_W'(hdr.prg_banks) * LEN_W'(PRG_UNIT_BYTES);
      SEC_CHR:     len = LEN_W'(hdr.chr_banks) * LEN_W'(CHR_UNIT_BYTES);
      SEC_INST:    len = hdr.inst ? LEN_W'(INST_ROM_BYTES) : '0;
      default:     len = '0;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/isr_parser.sv
// isr_parser: section/offset tracking and header capture, one byte per step
// depends on isr_pkg
module isr_parser import isr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  isr_in_t  in_i,
  output isr_out_t res_o
);

  logic [SEC_W-1:0] sec_q, sec_d, sec_base;
  logic [OFF_W-1:0] off_q, off_d, off_base;
  isr_hdr_t         hdr_q, hdr_d, hdr_base;
  logic [LEN_W-1:0] off_inc;
  logic [SEC_W-1:0] sec_next;

  always_comb begin
    if (in_i.image_start) begin
      sec_base = SEC_HEADER;
      off_base = '0;
      hdr_base = '0;
    end else begin
      sec_base = sec_q;
      off_base = off_q;
      hdr_base = hdr_q;
    end

    hdr_d = hdr_base;
    if (sec_base == SEC_HEADER) begin
      case (off_base)
        HDR_PRG_OFF:  hdr_d.prg_banks = in_i.rom_byte;
        HDR_CHR_OFF:  hdr_d.chr_banks = in_i.rom_byte;
        HDR_FLG6_OFF: hdr_d.trainer   = in_i.rom_byte[TRAINER_BIT];
        HDR_FLG7_OFF: hdr_d.inst      = in_i.rom_byte[INST_BIT];
        default: ;
      endcase
    end

    // first non-empty section after the current one
    sec_next = SEC_TRAILING;
    for (int t = int'(SEC_INST); t > int'(SEC_HEADER); t--) begin
      if (SEC_W'(t) > sec_base && section_len(SEC_W'(t), hdr_d) != '0) begin
        sec_next = SEC_W'(t);
      end
    end

    off_inc = LEN_W'(off_base) + LEN_W'(1);
    if (sec_base >= SEC_TRAILING) begin
      sec_d = SEC_TRAILING;
      off_d = (off_base != OFFSET_MAX) ? off_inc[OFF_W-1:0] : off_base;
    end else if (off_inc >= section_len(sec_base, hdr_d)) begin
      sec_d = sec_next;
      off_d = '0;
    end else begin
      sec_d = sec_base;
      off_d = off_inc[OFF_W-1:0];
    end

    res_o.section          = sec_base;
    res_o.section_offset   = off_base;
    res_o.byte_out         = in_i.rom_byte;
    res_o.prg_banks        = hdr_d.prg_banks;
    res_o.chr_banks        = hdr_d.chr_banks;
    res_o.trainer_present  = hdr_d.trainer;
    res_o.inst_rom_present = hdr_d.inst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q <= SEC_HEADER;
      off_q <= '0;
      hdr_q <= '0;
    end else if (step_i) begin
      sec_q <= sec_d;
      off_q <= off_d;
      hdr_q <= hdr_d;
    end
  end

endmodule

>>> rtl/ines_image_section_router.sv
// ines_image_section_router: top level with input and result registers
// depends on isr_pkg and isr_parser
//
// Usage: cartridge image bytes enter on in_data_i, one transfer per byte,
// with image_start set on the first byte of each image. Each byte yields
// one result on out_data_o: its section, its offset in that section, the
// byte itself and the header counts and flags captured so far.
// A byte passes the input register and then the result register before it is shown.
// Throughput: one byte per cycle, sustained while out_stall_i is low.
// The input register and the result register each hold one item; a new
// byte is taken while a finished result waits on the output.
// When the receiver stalls, the result register holds, then the input
// register fills and in_stall_o rises until the result is taken.
// Reset clears the valid flags of both registers and the parser state, which
// then equals the state at the start of a fresh image.
module ines_image_section_router import isr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  isr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output isr_out_t out_data_o
);

  logic     in_valid_q, in_valid_d;
  isr_in_t  in_data_q;
  logic     out_valid_q, out_valid_d;
  isr_out_t out_data_q;
  isr_out_t res;
  logic     in_xfer, adv;

  assign adv        = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  isr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .in_i   (in_data_q),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= in_data_i;
    end
    if (adv) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_hdr_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.section == SEC_HEADER
      |-> out_data_o.section_offset < OFF_W'(HEADER_BYTES))
    else $error("header offset beyond header length");

  a_prg_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.section == SEC_PRG |-> out_data_o.prg_banks != 8'd0)
    else $error("prg section with zero bank count");

  a_trainer_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.section == SEC_TRAINER |-> out_data_o.trainer_present)
    else $error("trainer section without trainer flag");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled while pipeline has room");

endmodule
